// ===== rtl/core/assert_macros.svh =====
// assertion macros for the calibrator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/mhsic_pkg.sv =====
// types, widths and codes shared by the magnetometer calibrator modules
package mhsic_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 12;

    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam int GAIN_W   = GAIN_FRAC_BITS + 4;
    localparam int SUM_W    = SAMPLE_BITS + 2;
    localparam int DEN_W    = SAMPLE_BITS + 2;
    localparam int NUM_W    = SUM_W + GAIN_FRAC_BITS + 1;
    localparam int CNT_W    = $clog2(NUM_W);
    localparam int PROD_W   = SAMPLE_BITS + GAIN_W;
    localparam int RND_W    = PROD_W - GAIN_FRAC_BITS + 1;
    localparam int SPAN_W   = SAMPLE_BITS;
    localparam int CFG_W    = 16;

    localparam logic [SAMPLE_BITS-1:0] SMAX_C = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN_C = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [GAIN_W-1:0]      GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [GAIN_W-1:0]      GAIN_MAX = {GAIN_W{1'b1}};
    localparam logic [CFG_W-1:0]       MIN_SPAN_RST = CFG_W'(1);

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_FEED   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_APPLY  = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_DEGEN   = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_APPLY,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic              load_in;
        logic              start_cap;
        logic              feed;
        logic              fin_bounds;
        logic              fin_sum;
        logic              div_start;
        logic              gain_wr;
        logic              set_calib;
        logic              mul_en;
        logic              rnd_en;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      degen;
        logic      div_done;
    } dp_stat_t;

endpackage

// ===== rtl/core/mhsic_div.sv =====
// restoring divider, one quotient bit per cycle, used for the soft-iron gains
module mhsic_div
    import mhsic_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/mhsic_dp.sv =====
// calibrator datapath: bounds, offsets, gains, correction and output word
module mhsic_dp
    import mhsic_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic [1:0]                 in_cmd,
    input  logic [AXES*SAMPLE_BITS-1:0] in_samples,
    input  logic                       min_span_we,
    input  logic [CFG_W-1:0]           min_span_in,
    output logic [AXES*SAMPLE_BITS-1:0] out_data,
    output logic [2:0]                 out_user
);

    // calibration state
    logic signed [SAMPLE_BITS-1:0] min_reg  [AXES];
    logic signed [SAMPLE_BITS-1:0] max_reg  [AXES];
    logic signed [SAMPLE_BITS-1:0] hard_reg [AXES];
    logic [GAIN_W-1:0]             gain_reg [AXES];
    logic                          any_seen_reg;
    logic                          capture_reg;
    logic                          calib_reg;
    logic                          degen_reg;
    logic [CFG_W-1:0]              min_span_reg;

    // per-item working registers
    cmd_code_t                     cmd_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [AXES];
    logic [SPAN_W-1:0]             span_reg [AXES];
    logic [SUM_W-1:0]              sum_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          neg_reg;
    logic [AXIS_W-1:0]             prod_axis_reg;
    logic [SAMPLE_BITS-1:0]        corr_reg [AXES];
    status_code_t                  status_reg;
    logic [AXES*SAMPLE_BITS-1:0]   out_data_reg;
    logic [2:0]                    out_user_reg;

    logic signed [SAMPLE_BITS-1:0] off_new  [AXES];
    logic [SPAN_W-1:0]             span_new [AXES];
    logic [CFG_W-1:0]              need;
    logic                          degen_new;

    logic [DEN_W-1:0]              div_den;
    logic [NUM_W-1:0]              div_num;
    logic                          div_done;
    logic [NUM_W-1:0]              div_quo;
    logic [GAIN_W-1:0]             gain_sat;

    logic signed [SAMPLE_BITS:0]   diff_ext;
    logic [SAMPLE_BITS:0]          diff_abs;
    logic [RND_W-1:0]              q_rnd;
    logic [PROD_W:0]               prod_rnd;
    logic [SAMPLE_BITS-1:0]        corr_new;

    // offsets and spans from the held bounds
    always_comb
    begin
        logic signed [SAMPLE_BITS:0] bsum;
        logic signed [SAMPLE_BITS:0] bdiff;
        need      = (min_span_reg == '0) ? CFG_W'(1) : min_span_reg;
        degen_new = !any_seen_reg;
        for (int i = 0; i < AXES; i++)
        begin
            bsum  = {min_reg[i][SAMPLE_BITS-1], min_reg[i]}
                  + {max_reg[i][SAMPLE_BITS-1], max_reg[i]};
            bdiff = {max_reg[i][SAMPLE_BITS-1], max_reg[i]}
                  - {min_reg[i][SAMPLE_BITS-1], min_reg[i]};
            if (any_seen_reg)
            begin
                off_new[i]  = bsum[SAMPLE_BITS:1];
                span_new[i] = bdiff[SPAN_W-1:0];
            end
            else
            begin
                off_new[i]  = '0;
                span_new[i] = '0;
            end
            if (CFG_W'(span_new[i]) < need)
                degen_new = 1'b1;
        end
    end

    // divider operands: gain = (sum * 2^F + 3*span/2) / (3*span)
    assign div_den = {1'b0, span_reg[cmd.axis], 1'b0} + DEN_W'(span_reg[cmd.axis]);
    assign div_num = {1'b0, sum_reg, {GAIN_FRAC_BITS{1'b0}}} + NUM_W'(div_den >> 1);

    mhsic_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign gain_sat = (div_quo[NUM_W-1:GAIN_W] != '0) ? GAIN_MAX : div_quo[GAIN_W-1:0];

    // multiply stage: magnitude of sample minus offset
    assign diff_ext = {samp_reg[cmd.axis][SAMPLE_BITS-1], samp_reg[cmd.axis]}
                    - {hard_reg[cmd.axis][SAMPLE_BITS-1], hard_reg[cmd.axis]};
    assign diff_abs = diff_ext[SAMPLE_BITS] ? -diff_ext : diff_ext;

    // round stage: nearest, halves away from zero, then saturate
    assign prod_rnd = {1'b0, prod_reg} + (PROD_W+1)'(1 << (GAIN_FRAC_BITS - 1));
    assign q_rnd    = prod_rnd[PROD_W:GAIN_FRAC_BITS];

    always_comb
    begin
        if (!neg_reg)
            corr_new = (q_rnd > RND_W'(SMAX_C)) ? SMAX_C : q_rnd[SAMPLE_BITS-1:0];
        else
            corr_new = (q_rnd > RND_W'(SMIN_C)) ? SMIN_C : -q_rnd[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                min_reg[i]  <= SMAX_C;
                max_reg[i]  <= SMIN_C;
                hard_reg[i] <= '0;
                gain_reg[i] <= GAIN_ONE;
            end
            any_seen_reg <= 1'b0;
            capture_reg  <= 1'b0;
            calib_reg    <= 1'b0;
            min_span_reg <= MIN_SPAN_RST;
        end
        else
        begin
            if (min_span_we)
                min_span_reg <= min_span_in;
            if (cmd.start_cap)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    min_reg[i] <= SMAX_C;
                    max_reg[i] <= SMIN_C;
                end
                any_seen_reg <= 1'b0;
                capture_reg  <= 1'b1;
            end
            if (cmd.feed && capture_reg)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    if (samp_reg[i] < min_reg[i])
                        min_reg[i] <= samp_reg[i];
                    if (samp_reg[i] > max_reg[i])
                        max_reg[i] <= samp_reg[i];
                end
                any_seen_reg <= 1'b1;
            end
            if (cmd.fin_bounds)
            begin
                for (int i = 0; i < AXES; i++)
                    hard_reg[i] <= off_new[i];
                capture_reg <= 1'b0;
            end
            if (cmd.gain_wr)
                gain_reg[cmd.axis] <= gain_sat;
            if (cmd.set_calib)
                calib_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg    <= cmd_code_t'(in_cmd);
            for (int i = 0; i < AXES; i++)
            begin
                samp_reg[i] <= in_samples[i*SAMPLE_BITS +: SAMPLE_BITS];
                corr_reg[i] <= '0;
            end
            status_reg <= STATUS_DONE;
        end
        if (cmd.feed && !capture_reg)
            status_reg <= STATUS_IGNORED;
        if (cmd.fin_bounds)
        begin
            for (int i = 0; i < AXES; i++)
                span_reg[i] <= span_new[i];
            degen_reg <= degen_new;
            if (degen_new)
                status_reg <= STATUS_DEGEN;
        end
        if (cmd.fin_sum)
            sum_reg <= SUM_W'(span_reg[0]) + SUM_W'(span_reg[1]) + SUM_W'(span_reg[2]);
        if (cmd.mul_en)
        begin
            prod_reg      <= diff_abs[SAMPLE_BITS-1:0] * gain_reg[cmd.axis];
            neg_reg       <= diff_ext[SAMPLE_BITS];
            prod_axis_reg <= cmd.axis;
        end
        if (cmd.rnd_en)
            corr_reg[prod_axis_reg] <= corr_new;
        if (cmd.out_load)
        begin
            for (int i = 0; i < AXES; i++)
                out_data_reg[i*SAMPLE_BITS +: SAMPLE_BITS] <= corr_reg[i];
            out_user_reg <= {calib_reg, status_reg};
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.degen    = degen_reg;
    assign stat.div_done = div_done;
    assign out_data      = out_data_reg;
    assign out_user      = out_user_reg;

endmodule

// ===== rtl/core/mhsic_ctrl.sv =====
// calibrator controller: command sequencing and output word handshake
module mhsic_ctrl
    import mhsic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.cmd)
                    CMD_START:
                    begin
                        cmd.start_cap = 1'b1;
                        state_next    = ST_RESP;
                    end
                    CMD_FEED:
                    begin
                        cmd.feed   = 1'b1;
                        state_next = ST_RESP;
                    end
                    CMD_FINISH:
                    begin
                        cmd.fin_bounds = 1'b1;
                        state_next     = ST_FIN_SUM;
                    end
                    CMD_APPLY:
                    begin
                        axis_next  = '0;
                        state_next = ST_APPLY;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_FIN_SUM:
            begin
                cmd.fin_sum = 1'b1;
                axis_next   = '0;
                state_next  = stat.degen ? ST_RESP : ST_DIV_START;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.gain_wr = 1'b1;
                    if (axis_reg == AXIS_W'(AXES - 1))
                    begin
                        cmd.set_calib = 1'b1;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        axis_next  = axis_reg + AXIS_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_APPLY:
            begin
                // multiply for this axis overlaps rounding of the previous one
                cmd.mul_en = axis_reg != AXIS_W'(AXES);
                cmd.rnd_en = axis_reg != '0;
                if (axis_reg == AXIS_W'(AXES))
                    state_next = ST_RESP;
                else
                    axis_next = axis_reg + AXIS_W'(1);
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/magnetometer_hard_soft_iron_calibrator.sv =====
// top level of the min/max hard- and soft-iron magnetometer calibrator
// One word in, one word out. Start and feed words pass through exec and respond before
// the next word can be accepted; apply serves the three axes in turn with one shared
// 16x16 multiplier, a degenerate finish skips the gain divisions, and in a full finish
// the three gain divisions share one restoring divider that retires one quotient
// bit per cycle of its 31-bit quotient per axis. A new word is accepted while the
// previous result still waits in the output register; the block stalls only when a
// second result is ready before the first has been taken.
`include "assert_macros.svh"

module magnetometer_hard_soft_iron_calibrator
    import mhsic_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        min_span_we,
    input  logic [CFG_W-1:0]            min_span,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // sample_x, sample_y, sample_z
    input  logic [AXES*SAMPLE_BITS-1:0] s_tdata,
    // cmd
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // corrected_x, corrected_y, corrected_z
    output logic [AXES*SAMPLE_BITS-1:0] m_tdata,
    // status, is_calibrated
    output logic [2:0]                  m_tuser
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    mhsic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    mhsic_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .in_cmd      (s_tuser),
        .in_samples  (s_tdata),
        .min_span_we (min_span_we),
        .min_span_in (min_span),
        .out_data    (m_tdata),
        .out_user    (m_tuser)
    );

    // one word in flight at a time
    `CHK_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // output register only reloads once the held word is gone
    `CHK_IMPLY(a_load_when_free, dp_cmd.out_load, !m_tvalid || m_tready)
    `CHK_IMPLY(a_status_code, m_tvalid, m_tuser[1:0] <= STATUS_DEGEN)
    // divider only finishes inside a finish command
    `CHK_IMPLY(a_div_inside_finish, dp_stat.div_done, !s_tready)

endmodule
